### rtl/core/sfd_pkg.sv
// Package for the SBUS frame decoder: frame layout constants, register
// indexes and the frame hand-over structure. No dependencies.
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int unsigned CHANNELS   = 16;
    localparam int unsigned VALUE_W    = 11;
    localparam int unsigned DATA_BYTES = 22;
    localparam int unsigned DATA_W     = DATA_BYTES * 8;
    localparam int unsigned CH_W       = $clog2(CHANNELS);
    localparam int unsigned POS_W      = 5;

    localparam logic [POS_W-1:0] POS_FIRST_DATA = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LAST_DATA  = POS_W'(DATA_BYTES);
    localparam logic [POS_W-1:0] POS_STATUS     = POS_W'(23);
    localparam logic [POS_W-1:0] POS_FOOTER     = POS_W'(24);

    localparam logic [7:0] FOOTER_VALUE  = 8'h00;
    localparam int unsigned LOST_BIT     = 3;
    localparam int unsigned FAILSAFE_BIT = 4;

    localparam logic [7:0] HEADER_FIRST_RST  = 8'h0F;
    localparam logic [7:0] HEADER_SECOND_RST = 8'h1B;
    localparam logic [7:0] HEADER_THIRD_RST  = 8'h2B;

    localparam int unsigned CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_FIRST  = 2'd0,
        CFG_HEADER_SECOND = 2'd1,
        CFG_HEADER_THIRD  = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_index;

    // A completed frame handed from the byte assembler to the result drain.
    typedef struct packed {
        logic              load;
        logic              ok;
        logic [7:0]        status;
        logic [DATA_W-1:0] data;
    } t_frame_evt;

endpackage

### rtl/core/sfd_assembler.sv
// Byte assembler for the SBUS frame decoder: holds the header registers,
// tracks the byte position and collects the data and status bytes.
// Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_assembler (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [sfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                 i_cfg_data,
    input  logic                       i_valid,
    input  logic [7:0]                 i_byte,
    input  logic                       i_start,
    input  logic                       i_drain_busy,
    output logic                       o_ready,
    output sfd_pkg::t_frame_evt        o_evt
);
    import sfd_pkg::*;

    logic [7:0]        r_hdr_first, r_hdr_second, r_hdr_third;
    logic [DATA_W-1:0] r_data;
    logic [7:0]        r_status;
    logic [POS_W-1:0]  r_pos;
    logic              r_in_frame;
    logic              r_match;
    logic              w_accept;
    logic              w_at_footer;

    assign w_at_footer = r_in_frame && (r_pos == POS_FOOTER);
    assign o_ready     = !(w_at_footer && i_drain_busy);
    assign w_accept    = i_valid && o_ready;

    assign o_evt.load   = w_accept && !i_start && w_at_footer;
    assign o_evt.ok     = r_match && (i_byte == FOOTER_VALUE);
    assign o_evt.status = r_status;
    assign o_evt.data   = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_first  <= HEADER_FIRST_RST;
            r_hdr_second <= HEADER_SECOND_RST;
            r_hdr_third  <= HEADER_THIRD_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_HEADER_FIRST:  r_hdr_first  <= i_cfg_data;
                CFG_HEADER_SECOND: r_hdr_second <= i_cfg_data;
                CFG_HEADER_THIRD:  r_hdr_third  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_in_frame <= 1'b0;
            r_match    <= 1'b0;
            r_status   <= '0;
        end else if (w_accept) begin
            priority if (i_start) begin
                r_match    <= (i_byte == r_hdr_first) || (i_byte == r_hdr_second) ||
                              (i_byte == r_hdr_third);
                r_in_frame <= 1'b1;
                r_pos      <= POS_FIRST_DATA;
            end else if (!r_in_frame) begin
                r_pos <= '0;
            end else if (r_pos <= POS_LAST_DATA) begin
                r_pos <= r_pos + POS_W'(1);
            end else if (r_pos == POS_STATUS) begin
                r_status <= i_byte;
                r_pos    <= r_pos + POS_W'(1);
            end else begin
                r_in_frame <= 1'b0;
                r_pos      <= '0;
            end
        end
    end

    // Data bytes shift in from the top, so the first data byte ends up in
    // the lowest bits once all of them have arrived.
    always_ff @(posedge i_clk) begin
        if (w_accept && !i_start && r_in_frame && r_pos <= POS_LAST_DATA) begin
            r_data <= {i_byte, r_data[DATA_W-1:8]};
        end
    end

endmodule

### rtl/core/sfd_drain.sv
// Result drain for the SBUS frame decoder: holds a completed frame and
// presents one channel result per transaction. Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_drain (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sfd_pkg::t_frame_evt       i_evt,
    input  logic                      i_ready,
    output logic                      o_busy,
    output logic                      o_valid,
    output logic [sfd_pkg::CH_W-1:0]    o_channel_index,
    output logic [sfd_pkg::VALUE_W-1:0] o_channel_value,
    output logic                      o_frame_good,
    output logic [7:0]                o_status_byte,
    output logic                      o_link_lost,
    output logic                      o_failsafe,
    output logic                      o_last
);
    import sfd_pkg::*;

    logic              r_busy, n_busy;
    logic [CH_W-1:0]   r_ch, n_ch;
    logic [DATA_W-1:0] r_snap, n_snap;
    logic [7:0]        r_status, n_status;
    logic              r_ok, n_ok;
    logic              w_last;

    assign w_last = !r_ok || (r_ch == CH_W'(CHANNELS - 1));

    always_comb begin
        n_busy   = r_busy;
        n_ch     = r_ch;
        n_snap   = r_snap;
        n_status = r_status;
        n_ok     = r_ok;
        if (i_evt.load) begin
            n_busy   = 1'b1;
            n_ch     = '0;
            n_ok     = i_evt.ok;
            n_snap   = i_evt.ok ? i_evt.data : '0;
            n_status = i_evt.ok ? i_evt.status : 8'h00;
        end else if (r_busy && i_ready) begin
            if (w_last) begin
                n_busy = 1'b0;
            end else begin
                n_ch   = r_ch + CH_W'(1);
                n_snap = r_snap >> VALUE_W;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch     <= n_ch;
        r_snap   <= n_snap;
        r_status <= n_status;
        r_ok     <= n_ok;
    end

    assign o_busy          = r_busy;
    assign o_valid         = r_busy;
    assign o_channel_index = r_ch;
    assign o_channel_value = r_snap[VALUE_W-1:0];
    assign o_frame_good    = r_ok;
    assign o_status_byte   = r_status;
    assign o_link_lost     = r_status[LOST_BIT];
    assign o_failsafe      = r_status[FAILSAFE_BIT];
    assign o_last          = w_last;

endmodule

### rtl/core/sbus_frame_decoder.sv
// Top level of the SBUS frame decoder: byte stream in, channel results out.
// Depends on sfd_pkg, sfd_assembler and sfd_drain.
`timescale 1ns / 1ps

// The decoder takes one frame byte per clock cycle on the slave stream,
// with tuser set on the header byte, and answers each 25-byte frame on the
// master stream with 16 channel results (one per cycle while tready is
// high) or, for a bad header or footer, a single result with tuser clear
// and all data zero. The first result is offered in the cycle after the
// footer byte is accepted. Results of one frame drain while the next
// frame's bytes are taken in; only the byte at the footer position of the
// next frame waits, with s_axis_tready low, until the cycle after the
// previous frame's last result has been taken. The user must write header
// values through the configuration port only while idle; it is unenforced.
module sbus_frame_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [sfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
    input  logic [0:0]                    s_axis_tuser,  // [0] frame_start
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [3:0] channel_index, [14:4] channel_value, [22:15] status_byte,
    // [23] link_lost, [24] failsafe, [31:25] zero
    output logic [31:0]                   m_axis_tdata,
    output logic [0:0]                    m_axis_tuser,  // [0] frame_good
    output logic                          m_axis_tlast
);
    import sfd_pkg::*;

    t_frame_evt         w_evt;
    logic               w_busy;
    logic [CH_W-1:0]    w_index;
    logic [VALUE_W-1:0] w_value;
    logic [7:0]         w_status;
    logic               w_lost, w_failsafe, w_ok;

    sfd_assembler u_asm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (s_axis_tvalid),
        .i_byte       (s_axis_tdata),
        .i_start      (s_axis_tuser[0]),
        .i_drain_busy (w_busy),
        .o_ready      (s_axis_tready),
        .o_evt        (w_evt)
    );

    sfd_drain u_drain (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_evt           (w_evt),
        .i_ready         (m_axis_tready),
        .o_busy          (w_busy),
        .o_valid         (m_axis_tvalid),
        .o_channel_index (w_index),
        .o_channel_value (w_value),
        .o_frame_good    (w_ok),
        .o_status_byte   (w_status),
        .o_link_lost     (w_lost),
        .o_failsafe      (w_failsafe),
        .o_last          (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0, w_failsafe, w_lost, w_status, w_value, w_index};
    assign m_axis_tuser = w_ok;

endmodule

### rtl/core/sfd_checker.sv
// Port-level checks for the SBUS frame decoder, bound to the top level.
// Depends on sbus_frame_decoder.
`timescale 1ns / 1ps

module sfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A result that waits for the sink stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Result withdrawn before its transaction completed.");

    // A bad frame is a single, all-zero result that closes the frame.
    a_bad_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 32'h0))
        else $error("Bad-frame result is not a zeroed final result.");

    // Channel results follow each other in index order without a gap.
    a_next_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tdata[3:0] == $past(m_axis_tdata[3:0]) + 4'd1))
        else $error("Channel results are out of order.");

    // A good frame ends on the last channel.
    a_good_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] && m_axis_tlast |-> m_axis_tdata[3:0] == 4'd15)
        else $error("Good frame ended before its last channel.");

endmodule

bind sbus_frame_decoder sfd_checker u_sfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
